// ===== rtl/trigger_pulse_timestamper_assert.svh =====
// Assertion macros used by the checker of the trigger timestamper.
`ifndef TRIGGER_PULSE_TIMESTAMPER_ASSERT_SVH
`define TRIGGER_PULSE_TIMESTAMPER_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define TPT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("trigger timestamper check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define TPT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("trigger timestamper check failed");

`endif

// ===== rtl/tpt_pkg.sv =====
// Shared types and constants of the trigger timestamper.
`default_nettype none
package tpt_pkg;

	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 32;
	localparam int CD_W       = 10;

	localparam logic [CFG_ADDR_W-1:0] REG_PERIOD   = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_PULSE    = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_COMPARE  = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_REMAIN   = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] REG_CLK_RATE = 3'd4;

	localparam logic [CD_W-1:0] PERIOD_RST   = 10'd625;
	localparam logic [CD_W-1:0] PULSE_RST    = 10'd10;
	localparam logic [7:0]      COMPARE_RST  = 8'h7F;
	localparam logic [7:0]      REMAIN_RST   = 8'd22;
	localparam logic [31:0]     CLK_RATE_RST = 32'd16000000;

	// Host command bytes
	localparam logic [7:0] CMD_START = 8'h67; // g
	localparam logic [7:0] CMD_STOP  = 8'h73; // s
	localparam logic [7:0] CMD_FREQ  = 8'h66; // f
	localparam logic [7:0] CMD_TEMP  = 8'h74; // t
	localparam logic [7:0] CMD_TIME  = 8'h54; // T

	// Packet header and trailer bytes
	localparam logic [7:0] PK_STATE = 8'h72; // r
	localparam logic [7:0] PK_FREQ  = 8'h66; // f
	localparam logic [7:0] PK_TEMP  = 8'h74; // t
	localparam logic [7:0] PK_TRIG  = 8'h54; // T
	localparam logic [7:0] PK_QUERY = 8'h51; // Q
	localparam logic [7:0] PK_END   = 8'h58; // X

	// One finished request: levels after it, and the packet it sends, if any.
	// The payload is left aligned, its first byte in the top bits.
	typedef struct packed {
		logic        trig;
		logic        run;
		logic        has_bytes;
		logic [7:0]  kind;
		logic [3:0]  len;
		logic [63:0] payload;
	} pkt_t;

endpackage
`default_nettype wire

// ===== rtl/trigger_pulse_timestamper.sv =====
// Top level of the periodic trigger generator with packet timestamping.
//
//   Channel   Direction  Signals                       Carries
//   s_*       in         s_tvalid s_tready s_tdata     one tick or one host command byte
//                        s_tuser
//   m_*       out        m_tvalid m_tready m_tdata     one packet byte or a bare status
//                        m_tuser m_tlast
//   cfg_*     in         cfg_we cfg_addr cfg_wdata     register writes, no read-back
//
// A request is taken in the cycle it arrives if the result register is empty or is
// being emptied, so requests that answer with a single result flow at one per cycle.
// A request that sends a packet holds the input until the serialiser has sent all its
// bytes (4 to 11); the serialiser puts out one byte per cycle while the output is ready.
// Reset is asynchronous and active low; there is no clearing pass after it.
// A stalled output holds its byte and stops the input until the last byte goes.
`default_nettype none
module trigger_pulse_timestamper
	import tpt_pkg::*;
#(
	parameter int TIME_BITS     = 64,
	parameter int PRESCALE_BITS = 8
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [23:0]           s_tdata,  // command_byte[7:0], temperature_sample[17:8]
	input  wire logic                  s_tuser,  // func
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [15:0]                m_tdata,  // trigger_level[0], running[1], serial_byte[9:2]
	output logic                       m_tuser,  // byte_valid
	output logic                       m_tlast,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

	logic take;
	pkt_t pkt;

	// A request is taken only when the result register can take its answer.
	assign take = s_tvalid && s_tready;

	tpt_core #(
		.TIME_BITS     (TIME_BITS),
		.PRESCALE_BITS (PRESCALE_BITS)
	) u_core (
		.clk                (clk),
		.arst_n             (arst_n),
		.take               (take),
		.func               (s_tuser),
		.command_byte       (s_tdata[7:0]),
		.temperature_sample (s_tdata[17:8]),
		.cfg_we             (cfg_we),
		.cfg_addr           (cfg_addr),
		.cfg_wdata          (cfg_wdata),
		.pkt                (pkt)
	);

	// The serialiser turns each answer into one or more output results.
	tpt_ser u_ser (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (take),
		.pkt      (pkt),
		.free     (s_tready),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule
`default_nettype wire

// ===== rtl/tpt_core.sv =====
// Timer state, configuration registers and per-request next-state logic.
`default_nettype none
module tpt_core
	import tpt_pkg::*;
#(
	parameter int TIME_BITS     = 64,
	parameter int PRESCALE_BITS = 8
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  take,
	input  wire logic                  func,
	input  wire logic [7:0]            command_byte,
	input  wire logic [9:0]            temperature_sample,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	output pkt_t                       pkt
);

	localparam int CW = (PRESCALE_BITS > 8) ? PRESCALE_BITS : 8;

	logic [CD_W-1:0]          period_q, pulse_q;
	logic [7:0]               compare_q, remain_q;
	logic [31:0]              clk_rate_q;

	logic [TIME_BITS-1:0]     time_q, time_n;
	logic [PRESCALE_BITS-1:0] ps_q, ps_n, ps_inc;
	logic [CD_W-1:0]          cd_q, cd_n, cd_base;
	logic                     sp_q, sp_n, trig_q, trig_n, run_q, run_n;
	logic                     cmp, ovf, skip, rise, reload;
	logic [CW-1:0]            ps_back;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q   <= PERIOD_RST;
			pulse_q    <= PULSE_RST;
			compare_q  <= COMPARE_RST;
			remain_q   <= REMAIN_RST;
			clk_rate_q <= CLK_RATE_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_PERIOD:   period_q   <= cfg_wdata[CD_W-1:0];
				REG_PULSE:    pulse_q    <= cfg_wdata[CD_W-1:0];
				REG_COMPARE:  compare_q  <= cfg_wdata[7:0];
				REG_REMAIN:   remain_q   <= cfg_wdata[7:0];
				REG_CLK_RATE: clk_rate_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		time_n  = time_q;
		ps_n    = ps_q;
		cd_n    = cd_q;
		sp_n    = sp_q;
		trig_n  = trig_q;
		run_n   = run_q;
		rise    = 1'b0;
		skip    = 1'b0;
		reload  = 1'b0;
		cd_base = cd_q;
		ps_inc  = ps_q + 1'b1;
		cmp     = (CW'(ps_inc) == CW'(compare_q));
		ovf     = (ps_inc == '0);
		ps_back = CW'(ps_inc) - CW'(remain_q);

		pkt.has_bytes = 1'b0;
		pkt.kind      = '0;
		pkt.len       = '0;
		pkt.payload   = '0;

		if (!func) begin
			time_n = time_q + 1'b1;
			if (run_q) begin
				ps_n = ps_inc;
				if (cmp) begin
					if (cd_q == '0) begin
						if (!sp_q) begin
							ps_n = ps_back[PRESCALE_BITS-1:0];
							sp_n = 1'b1;
							skip = 1'b1;
						end else begin
							sp_n = 1'b0;
						end
					end
					if (!skip && (cd_q == pulse_q - 1'b1)) begin
						rise = 1'b1;
					end
				end
				if (ovf) begin
					reload  = (cd_q == '0) && (cd_q != pulse_q);
					cd_base = reload ? period_q : cd_q;
					cd_n    = cd_base - 1'b1;
				end
				// A fall in the same tick wins over a rise.
				if (reload) begin
					trig_n = 1'b0;
				end else if (rise) begin
					trig_n = 1'b1;
				end
				if (rise) begin
					pkt.has_bytes = 1'b1;
					pkt.kind      = PK_TRIG;
					pkt.len       = 4'd8;
					pkt.payload   = 64'(time_n);
				end
			end
		end else begin
			case (command_byte)
				CMD_START: begin
					run_n         = 1'b1;
					pkt.has_bytes = 1'b1;
					pkt.kind      = PK_STATE;
					pkt.len       = 4'd1;
					pkt.payload   = {8'd1, 56'd0};
				end
				CMD_STOP: begin
					run_n         = 1'b0;
					pkt.has_bytes = 1'b1;
					pkt.kind      = PK_STATE;
					pkt.len       = 4'd1;
					pkt.payload   = '0;
				end
				CMD_FREQ: begin
					pkt.has_bytes = 1'b1;
					pkt.kind      = PK_FREQ;
					pkt.len       = 4'd4;
					pkt.payload   = {clk_rate_q, 32'd0};
				end
				CMD_TEMP: begin
					pkt.has_bytes = 1'b1;
					pkt.kind      = PK_TEMP;
					pkt.len       = 4'd2;
					pkt.payload   = {6'd0, temperature_sample, 48'd0};
				end
				CMD_TIME: begin
					pkt.has_bytes = 1'b1;
					pkt.kind      = PK_QUERY;
					pkt.len       = 4'd8;
					pkt.payload   = 64'(time_q);
				end
				default: ;
			endcase
		end

		pkt.trig = trig_n;
		pkt.run  = run_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q <= '0;
			ps_q   <= '0;
			cd_q   <= '0;
			sp_q   <= 1'b0;
			trig_q <= 1'b0;
			run_q  <= 1'b0;
		end else if (take) begin
			time_q <= time_n;
			ps_q   <= ps_n;
			cd_q   <= cd_n;
			sp_q   <= sp_n;
			trig_q <= trig_n;
			run_q  <= run_n;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/tpt_ser.sv =====
// Result register and byte serialiser for reply and timestamp packets.
`default_nettype none
module tpt_ser
	import tpt_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        load,
	input  wire pkt_t        pkt,
	output logic             free,
	input  wire logic        m_tready,
	output logic             m_tvalid,
	output logic [15:0]      m_tdata,
	output logic             m_tuser,
	output logic             m_tlast
);

	logic       valid_q;
	logic [3:0] idx_q;
	pkt_t       pkt_q;
	logic [7:0] byte_out;
	logic       done;

	assign m_tlast  = !pkt_q.has_bytes || (idx_q == pkt_q.len + 4'd2);
	assign done     = valid_q && m_tready && m_tlast;
	assign free     = !valid_q || done;
	assign m_tvalid = valid_q;
	assign m_tuser  = pkt_q.has_bytes;
	assign m_tdata  = {6'd0, byte_out, pkt_q.run, pkt_q.trig};

	always_comb begin
		if (!pkt_q.has_bytes) begin
			byte_out = '0;
		end else if (idx_q == 4'd0) begin
			byte_out = pkt_q.kind;
		end else if (idx_q == 4'd1) begin
			byte_out = {4'd0, pkt_q.len};
		end else if (m_tlast) begin
			byte_out = PK_END;
		end else begin
			byte_out = pkt_q.payload[63:56];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (load) begin
			valid_q <= 1'b1;
			idx_q   <= '0;
		end else if (done) begin
			valid_q <= 1'b0;
		end else if (valid_q && m_tready) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	// Payload shifts up one byte for each payload byte sent.
	always_ff @(posedge clk) begin
		if (load) begin
			pkt_q <= pkt;
		end else if (valid_q && m_tready && !m_tlast && idx_q >= 4'd2) begin
			pkt_q.payload <= {pkt_q.payload[55:0], 8'd0};
		end
	end

endmodule
`default_nettype wire

// ===== rtl/tpt_checker.sv =====
// Port-level checker for the trigger timestamper, bound to the top level.
`default_nettype none
`include "trigger_pulse_timestamper_assert.svh"
module tpt_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [15:0] m_tdata,
	input wire logic        m_tuser,
	input wire logic        m_tlast
);

	// A stalled result keeps its contents.
	`TPT_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))

	// A result without a packet byte is the only result of its request.
	`TPT_ASSERT_NOW(a_bare_last, clk, arst_n, m_tvalid && !m_tuser, m_tlast && (m_tdata[9:2] == 8'd0))

	// The input waits only while a result is pending.
	`TPT_ASSERT_NOW(a_ready_free, clk, arst_n, !s_tready, m_tvalid)

	// A taken request always produces a result in the next cycle.
	`TPT_ASSERT_NEXT(a_req_result, clk, arst_n, s_tvalid && s_tready, m_tvalid)

endmodule

bind trigger_pulse_timestamper tpt_checker u_tpt_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
`default_nettype wire
